>>> hdl/gca_pkg.sv
package gca_pkg;

  localparam logic [15:0] SAT_ONE = 16'd32768;
  // low 32 bits of 6.67E-3 in 40 fraction bits; bit 32 of the constant is one
  localparam logic [31:0] GRAV_K_LO = 32'd3038775261;
  localparam logic [60:0] SQRT_BIT_START = 61'h1000_0000_0000_0000;

  localparam logic [2:0] REG_STATION_X = 3'd0;
  localparam logic [2:0] REG_STATION_Y = 3'd1;
  localparam logic [2:0] REG_STATION_DEPTH = 3'd2;
  localparam logic [2:0] REG_MODEL_MASK = 3'd3;
  localparam logic [2:0] REG_FILE_MASK = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_Q0, S_Q1, S_Q2, S_Q3, S_ZCHK, S_NORM, S_SQRT, S_DIV,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
    S_FIN
  } state_t;

  function automatic logic [15:0] clamp_sat(input logic signed [17:0] v);
    logic [15:0] res;
    if (v < 18'sd0) begin
      res = 16'd0;
    end else if (v > 18'sd32768) begin
      res = SAT_ONE;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/gravity_change_accumulator.sv
// Channel  | Handshake                   | Payload
// in       | in_valid / in_stall         | second_step .. last_cell
// out      | out_valid / out_stall       | delta_g, zero_distance_seen
// cfg      | cfg_write, cfg_index        | cfg_data
// A first-step item runs the mass states only. A second-step item also runs the distance,
// square root, divide and product states; an aquifer cell and a zero distance skip to the
// finish. One 32x32 multiplier is reused for every product; the normalize loop, the
// bit-serial square root and the restoring divide are iterative. Reset is synchronous;
// it clears the sum, stored mass, flag, out_valid and stations and sets the masks to ones.
// A result waits in the output register; a new item is taken while it waits, and only
// a second result stalls until the first is taken.
module gravity_change_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               second_step,
  input  logic [31:0]        pore_volume,
  input  logic signed [16:0] water_sat,
  input  logic signed [16:0] gas_sat,
  input  logic [15:0]        oil_density,
  input  logic [15:0]        gas_density,
  input  logic [15:0]        water_density,
  input  logic signed [31:0] cell_x,
  input  logic signed [31:0] cell_y,
  input  logic signed [31:0] cell_z,
  input  logic               is_aquifer,
  input  logic               last_cell,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] delta_g,
  output logic               zero_distance_seen
);
  import gca_pkg::*;

  state_t state, state_next;

  logic signed [31:0] station_x, station_y, station_depth;
  logic [2:0] model_mask;
  logic [1:0] file_mask;

  logic [31:0] pv;
  logic [15:0] sw, sg, so, dens_o, dens_g, dens_w;
  logic second_r, aquifer_r, last_r;
  logic signed [32:0] dx, dy, dz;
  logic [31:0] ax, ay, az;

  logic [63:0] prod;
  logic [127:0] acc;
  logic [31:0] mul_a, mul_b;
  logic [44:0] mass1;
  logic [44:0] dmag;
  logic neg;
  logic signed [6:0] k;
  logic [31:0] zn;
  logic [61:0] root, sbit;
  logic [31:0] rem, quo, q;
  logic [4:0] cnt;
  logic [75:0] pm;
  logic [62:0] mag;
  logic signed [63:0] sum;
  logic zflag;

  logic [15:0] sw_c, sg_c, so_c;
  logic signed [17:0] so_raw;
  logic [63:0] mass64;
  logic [44:0] mass;
  logic signed [45:0] dm;
  logic [61:0] sq_try;
  logic [32:0] div_t;
  logic [6:0] sh;
  logic [127:0] shifted;
  logic signed [64:0] c_ext, sum_ext;
  logic emit_ok;

  always_comb begin
    sw_c = clamp_sat({water_sat[16], water_sat});
    sg_c = 16'd0;
    if (model_mask[1]) begin
      sg_c = file_mask[1] ? clamp_sat({gas_sat[16], gas_sat}) : SAT_ONE - sw_c;
    end
    so_raw = 18'sd32768 - $signed({2'b00, sg_c}) - $signed({2'b00, sw_c});
    so_c = model_mask[2] ? clamp_sat(so_raw) : 16'd0;
  end

  assign ax = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay = dy[32] ? 32'(-dy) : dy[31:0];
  assign az = dz[32] ? 32'(-dz) : dz[31:0];

  assign mass64 = prod + (acc[32] ? {pv, 32'd0} : 64'd0) + 64'h4_0000;
  assign mass = mass64[63:19];
  assign dm = $signed({1'b0, mass}) - $signed({1'b0, mass1});

  assign sq_try = root + sbit;
  assign div_t = {rem, 1'b0};
  assign sh = 7'd94 + $unsigned(k);
  assign shifted = acc >> sh;
  assign c_ext = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign sum_ext = $signed({sum[63], sum}) + c_ext;
  assign emit_ok = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_M0: begin mul_a = {16'd0, so}; mul_b = {16'd0, dens_o}; end
      S_M1: begin mul_a = {16'd0, sg}; mul_b = {16'd0, dens_g}; end
      S_M2: begin mul_a = {16'd0, sw}; mul_b = {16'd0, dens_w}; end
      S_M4: begin mul_a = pv; mul_b = acc[31:0]; end
      S_Q0: begin mul_a = ax; mul_b = ax; end
      S_Q1: begin mul_a = ay; mul_b = ay; end
      S_Q2: begin mul_a = az; mul_b = az; end
      S_P0: begin mul_a = quo; mul_b = quo; end
      S_P1: begin mul_a = prod[62:31]; mul_b = quo; end
      S_P2: begin mul_a = prod[62:31]; mul_b = zn; end
      S_P3: begin mul_a = dmag[31:0]; mul_b = prod[62:31]; end
      S_P4: begin mul_a = {19'd0, dmag[44:32]}; mul_b = q; end
      S_P6: begin mul_a = pm[31:0]; mul_b = GRAV_K_LO; end
      S_P7: begin mul_a = pm[63:32]; mul_b = GRAV_K_LO; end
      S_P8: begin mul_a = {20'd0, pm[75:64]}; mul_b = GRAV_K_LO; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_M0;
      S_M0: state_next = S_M1;
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = S_M4;
      S_M4: state_next = S_M5;
      S_M5: begin
        if (!second_r) state_next = S_IDLE;
        else if (aquifer_r) state_next = S_FIN;
        else state_next = S_Q0;
      end
      S_Q0: state_next = S_Q1;
      S_Q1: state_next = S_Q2;
      S_Q2: state_next = S_Q3;
      S_Q3: state_next = S_ZCHK;
      S_ZCHK: state_next = (acc == 128'd0) ? S_FIN : S_NORM;
      S_NORM: if (acc[65:62] == 4'd0 && acc[61:60] != 2'd0) state_next = S_SQRT;
      S_SQRT: if (sbit[0]) state_next = S_DIV;
      S_DIV: if (cnt == 5'd31) state_next = S_P0;
      S_P0: state_next = S_P1;
      S_P1: state_next = S_P2;
      S_P2: state_next = S_P3;
      S_P3: state_next = S_P4;
      S_P4: state_next = S_P5;
      S_P5: state_next = S_P6;
      S_P6: state_next = S_P7;
      S_P7: state_next = S_P8;
      S_P8: state_next = S_P9;
      S_P9: state_next = S_P10;
      S_P10: state_next = S_P11;
      S_P11: state_next = S_FIN;
      S_FIN: if (!last_r || emit_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_x <= 32'sd0;
      station_y <= 32'sd0;
      station_depth <= 32'sd0;
      model_mask <= 3'd7;
      file_mask <= 2'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STATION_X: station_x <= cfg_data;
        REG_STATION_Y: station_y <= cfg_data;
        REG_STATION_DEPTH: station_depth <= cfg_data;
        REG_MODEL_MASK: model_mask <= cfg_data[2:0];
        REG_FILE_MASK: file_mask <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      S_IDLE: if (in_valid) begin
        pv <= pore_volume;
        sw <= sw_c;
        sg <= sg_c;
        so <= so_c;
        dens_o <= model_mask[2] ? oil_density : 16'd0;
        dens_g <= model_mask[1] ? gas_density : 16'd0;
        dens_w <= model_mask[0] ? water_density : 16'd0;
        second_r <= second_step;
        aquifer_r <= is_aquifer;
        last_r <= last_cell;
        dx <= $signed({cell_x[31], cell_x}) - $signed({station_x[31], station_x});
        dy <= $signed({cell_y[31], cell_y}) - $signed({station_y[31], station_y});
        dz <= $signed({cell_z[31], cell_z}) - $signed({station_depth[31], station_depth});
      end
      S_M1: acc <= {64'd0, prod};
      S_M2: acc <= acc + {64'd0, prod};
      S_M3: acc <= acc + {64'd0, prod};
      S_M5: begin
        dmag <= dm[45] ? 45'(-dm) : dm[44:0];
        neg <= dm[45] ^ dz[32];
      end
      S_Q0: begin
        zn <= az;
        k <= 7'sd0;
      end
      S_Q1: acc <= {64'd0, prod};
      S_Q2: acc <= acc + {64'd0, prod};
      S_Q3: acc <= acc + {64'd0, prod};
      S_NORM: begin
        if (acc[65:62] != 4'd0) begin
          acc <= acc >> 2;
          zn <= zn >> 1;
          k <= k + 7'sd2;
        end else if (acc[61:60] == 2'd0) begin
          acc <= acc << 2;
          zn <= zn << 1;
          k <= k - 7'sd2;
        end else begin
          root <= 62'd0;
          sbit <= {1'b0, SQRT_BIT_START};
        end
      end
      S_SQRT: begin
        if (acc[61:0] >= sq_try) begin
          acc <= {66'd0, acc[61:0] - sq_try};
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
        rem <= 32'h2000_0000;
        cnt <= 5'd0;
      end
      S_DIV: begin
        if (div_t >= {1'b0, root[31:0]}) begin
          rem <= 32'(div_t - {1'b0, root[31:0]});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= div_t[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      S_P3: q <= prod[62:31];
      S_P4: acc <= {64'd0, prod};
      S_P5: pm <= acc[75:0] + {prod[43:0], 32'd0};
      S_P6: acc <= {20'd0, pm, 32'd0};
      S_P7: acc <= acc + {64'd0, prod};
      S_P8: acc <= acc + {32'd0, prod, 32'd0};
      S_P9: acc <= acc + {prod, 64'd0};
      S_P10: mag <= (shifted[127:63] != 65'd0) ? {63{1'b1}} : shifted[62:0];
      default: ;
    endcase
  end

  // accumulated state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mass1 <= 45'd0;
      sum <= 64'sd0;
      zflag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_M5 && !second_r) mass1 <= mass;
      if (state == S_ZCHK && acc == 128'd0) zflag <= 1'b1;
      if (state == S_P11) begin
        if (sum_ext[64] != sum_ext[63]) begin
          sum <= sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          sum <= sum_ext[63:0];
        end
      end
      if (state == S_FIN && last_r && emit_ok) begin
        out_valid <= 1'b1;
        sum <= 64'sd0;
        zflag <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && last_r && emit_ok) begin
      delta_g <= sum;
      zero_distance_seen <= zflag;
    end
  end

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (root[61:31] == 31'd0 && root[30]))
    else $error("square root out of range");
  a_recip_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_P0) |-> (quo <= 32'h8000_0000))
    else $error("reciprocal out of range");
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (acc[127:62] == 66'd0))
    else $error("normalized distance too wide");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside finish");
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && last_r && emit_ok) |=> (sum == 64'sd0 && !zflag))
    else $error("sum not cleared after result");

endmodule
